>>> sv/iir3_pkg.sv
// ----------------------------------------------------------------------------
// iir3_pkg
// Shared widths, types, register codes and the rounding and saturation
// function for the third-order direct form I filter.
// ----------------------------------------------------------------------------
package iir3_pkg;

  localparam int SAMPLE_WIDTH   = 16;
  localparam int COEF_WIDTH     = 16;
  localparam int COEF_FRAC_BITS = 14;
  localparam int TAPS           = 3;
  localparam int CFG_IDX_W      = 3;

  localparam int PROD_W = SAMPLE_WIDTH + COEF_WIDTH;
  localparam int TERM_W = PROD_W + 1;
  localparam int ACC_W  = PROD_W + 3;
  localparam int QUOT_W = ACC_W - COEF_FRAC_BITS;

  typedef logic signed [SAMPLE_WIDTH-1:0] sample_t;
  typedef logic signed [COEF_WIDTH-1:0]   coef_t;
  typedef logic signed [PROD_W-1:0]       prod_t;
  typedef logic signed [TERM_W-1:0]       term_t;
  typedef logic signed [ACC_W-1:0]        acc_t;

  localparam sample_t SAMPLE_MAX = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
  localparam sample_t SAMPLE_MIN = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};

  // Reset values of the coefficients, Q2.14.
  localparam coef_t FF0_RESET = 16'sd1638;
  localparam coef_t FF1_RESET = 16'sd3277;
  localparam coef_t FF2_RESET = 16'sd4915;
  localparam coef_t FF3_RESET = 16'sd5734;
  localparam coef_t FB1_RESET = -16'sd8192;
  localparam coef_t FB2_RESET = 16'sd4096;
  localparam coef_t FB3_RESET = 16'sd4915;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FF0 = 3'd0,
    REG_FF1 = 3'd1,
    REG_FF2 = 3'd2,
    REG_FF3 = 3'd3,
    REG_FB1 = 3'd4,
    REG_FB2 = 3'd5,
    REG_FB3 = 3'd6
  } cfg_idx_e;

  typedef struct packed {
    sample_t sample_in;
    logic    restart;
  } in_beat_t;

  typedef struct packed {
    sample_t sample_out;
    logic    clipped;
  } out_beat_t;

  typedef struct packed {
    coef_t [TAPS:0] ff;
    coef_t [TAPS:1] fb;
  } coef_set_t;

  typedef struct packed {
    logic load;     // a new sample beat enters: shift x taps, register term
    logic shift_y;  // a result leaves the loop stage: shift y taps
  } cell_ctrl_t;

  // Round half up, floor to the sample grid, then saturate.
  function automatic out_beat_t sat_round(acc_t acc);
    acc_t                               rnd;
    logic signed [QUOT_W-1:0]           quot;
    logic [QUOT_W-SAMPLE_WIDTH:0]       high;
    logic                               fits;
    out_beat_t                          res;
    rnd  = acc + acc_t'(2 ** (COEF_FRAC_BITS - 1));
    quot = rnd[ACC_W-1:COEF_FRAC_BITS];
    high = quot[QUOT_W-1:SAMPLE_WIDTH-1];
    fits = (&high) | ~(|high);
    res.clipped    = ~fits;
    res.sample_out = fits ? quot[SAMPLE_WIDTH-1:0]
                          : (quot[QUOT_W-1] ? SAMPLE_MIN : SAMPLE_MAX);
    return res;
  endfunction

endpackage

>>> sv/iir3_coef_regs.sv
// ----------------------------------------------------------------------------
// iir3_coef_regs
// Coefficient register file, written through a plain write port.
// ----------------------------------------------------------------------------
module iir3_coef_regs
  import iir3_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [COEF_WIDTH-1:0] cfg_wdata_i,
  output coef_set_t            coef_o
);

  coef_set_t coef_q, coef_d;

  always_comb begin
    coef_d = coef_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        REG_FF0: coef_d.ff[0] = coef_t'(cfg_wdata_i);
        REG_FF1: coef_d.ff[1] = coef_t'(cfg_wdata_i);
        REG_FF2: coef_d.ff[2] = coef_t'(cfg_wdata_i);
        REG_FF3: coef_d.ff[3] = coef_t'(cfg_wdata_i);
        REG_FB1: coef_d.fb[1] = coef_t'(cfg_wdata_i);
        REG_FB2: coef_d.fb[2] = coef_t'(cfg_wdata_i);
        REG_FB3: coef_d.fb[3] = coef_t'(cfg_wdata_i);
        default: coef_d = coef_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coef_q.ff[0] <= FF0_RESET;
      coef_q.ff[1] <= FF1_RESET;
      coef_q.ff[2] <= FF2_RESET;
      coef_q.ff[3] <= FF3_RESET;
      coef_q.fb[1] <= FB1_RESET;
      coef_q.fb[2] <= FB2_RESET;
      coef_q.fb[3] <= FB3_RESET;
    end else begin
      coef_q <= coef_d;
    end
  end

  assign coef_o = coef_q;

endmodule

>>> sv/iir3_tap_cell.sv
// ----------------------------------------------------------------------------
// iir3_tap_cell
// One delay tap: holds one input and one output history sample, passes them
// on to the next cell, and registers that tap's weighted contribution.
// ----------------------------------------------------------------------------
module iir3_tap_cell
  import iir3_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  cell_ctrl_t ctrl_i,
  input  sample_t    x_in_i,
  input  sample_t    y_in_i,
  input  sample_t    x_op_i,
  input  sample_t    y_op_i,
  input  coef_t      ff_coef_i,
  input  coef_t      fb_coef_i,
  output sample_t    x_o,
  output sample_t    y_o,
  output term_t      term_o
);

  sample_t x_q, y_q;
  term_t   term_q;
  prod_t   ff_prod, fb_prod;
  term_t   term_d;

  assign ff_prod = ff_coef_i * x_op_i;
  assign fb_prod = fb_coef_i * y_op_i;
  assign term_d  = term_t'(ff_prod) - term_t'(fb_prod);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_q <= '0;
      y_q <= '0;
    end else begin
      if (ctrl_i.load) begin
        x_q <= x_in_i;
      end
      if (ctrl_i.shift_y) begin
        y_q <= y_in_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      term_q <= term_d;
    end
  end

  assign x_o    = x_q;
  assign y_o    = y_q;
  assign term_o = term_q;

endmodule

>>> sv/iir_filter_third_order.sv
// ----------------------------------------------------------------------------
// iir_filter_third_order
// Third-order direct form I IIR filter, Q1.15 samples, Q2.14 coefficients,
// rounded and saturated output with a clip flag.
// ----------------------------------------------------------------------------
// A sample beat accepted into the loop stage has its result registered in the
// output register once that register is free or is being emptied.
// Throughput: one sample per cycle unless the output stalls; the limit is the
// feedback loop through the first feedback multiplier, final sum and saturation.
// Reset: coefficients return to their defaults, both histories clear to zero
// and the pipeline empties. No clearing pass is needed.
module iir_filter_third_order
  import iir3_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  in_beat_t              in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output out_beat_t             out_data_o,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [COEF_WIDTH-1:0] cfg_wdata_i
);

  coef_set_t  coef;
  cell_ctrl_t cell_ctrl;

  sample_t x_tap  [1:TAPS];
  sample_t y_tap  [1:TAPS];
  sample_t x_in   [1:TAPS];
  sample_t y_in   [1:TAPS];
  sample_t x_op   [1:TAPS];
  sample_t y_op   [1:TAPS];
  coef_t   fb_use [1:TAPS];
  term_t   term   [1:TAPS];

  logic      in_acc, s2_go;
  logic      s2_v_q, s2_restart_q;
  prod_t     p0_q;
  prod_t     ff0_prod, fb1_prod;
  acc_t      acc;
  out_beat_t res;
  logic      out_v_q;
  out_beat_t out_q;

  iir3_coef_regs u_coef (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i),
    .coef_o     (coef)
  );

  // The loop stage finishes when the output register is free or being emptied.
  assign s2_go      = s2_v_q && (!out_v_q || !out_stall_i);
  assign in_stall_o = s2_v_q && !s2_go;
  assign in_acc     = in_valid_i && !in_stall_o;

  assign cell_ctrl.load    = in_acc;
  assign cell_ctrl.shift_y = s2_go;

  always_comb begin
    for (int k = 1; k <= TAPS; k++) begin
      if (k == 1) begin
        x_in[k]   = in_data_i.sample_in;
        y_in[k]   = res.sample_out;
        y_op[k]   = '0;
        fb_use[k] = '0;
      end else begin
        x_in[k]   = in_data_i.restart ? sample_t'(0) : x_tap[k-1];
        y_in[k]   = s2_restart_q ? sample_t'(0) : y_tap[k-1];
        fb_use[k] = coef.fb[k];
        // When the previous beat completes at this same edge its result is
        // not yet in the taps, so the y operand is taken one tap earlier.
        if (in_data_i.restart) begin
          y_op[k] = '0;
        end else if (s2_v_q) begin
          y_op[k] = s2_restart_q ? sample_t'(0) : y_tap[k-1];
        end else begin
          y_op[k] = y_tap[k];
        end
      end
      x_op[k] = in_data_i.restart ? sample_t'(0) : x_tap[k];
    end
  end

  for (genvar k = 1; k <= TAPS; k++) begin : g_cell
    iir3_tap_cell u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .ctrl_i   (cell_ctrl),
      .x_in_i   (x_in[k]),
      .y_in_i   (y_in[k]),
      .x_op_i   (x_op[k]),
      .y_op_i   (y_op[k]),
      .ff_coef_i(coef.ff[k]),
      .fb_coef_i(fb_use[k]),
      .x_o      (x_tap[k]),
      .y_o      (y_tap[k]),
      .term_o   (term[k])
    );
  end

  assign ff0_prod = coef.ff[0] * in_data_i.sample_in;
  assign fb1_prod = coef.fb[1] * y_tap[1];

  always_comb begin
    acc = acc_t'(p0_q);
    for (int k = 1; k <= TAPS; k++) begin
      acc = acc + acc_t'(term[k]);
    end
    if (!s2_restart_q) begin
      acc = acc - acc_t'(fb1_prod);
    end
  end

  assign res = sat_round(acc);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      if (in_acc) begin
        s2_v_q <= 1'b1;
      end else if (s2_go) begin
        s2_v_q <= 1'b0;
      end
      if (s2_go) begin
        out_v_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_v_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      p0_q         <= ff0_prod;
      s2_restart_q <= in_data_i.restart;
    end
    if (s2_go) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_v_q;
  assign out_data_o  = out_q;

  a_no_stall_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s2_v_q |-> !in_stall_o)
    else $error("input stalled while the loop stage is empty");

  a_result_registered: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s2_go |=> out_valid_o)
    else $error("finished beat did not reach the output register");

  a_clip_at_rail: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.clipped) |->
      (out_data_o.sample_out == SAMPLE_MAX || out_data_o.sample_out == SAMPLE_MIN))
    else $error("clipped result is not at a rail");

  a_restart_clears_y: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s2_go && s2_restart_q) |=> (y_tap[2] == '0 && y_tap[3] == '0))
    else $error("output history not cleared after a restart beat");

endmodule
